FILE: src/tem_pkg.sv
package tem_pkg;

    // default sizes
    localparam int NUM_TIMELINES_DEF        = 8;
    localparam int ENTRIES_PER_TIMELINE_DEF = 64;

    // field widths
    localparam int TIME_W   = 32;
    localparam int PAY_W    = 32;
    localparam int TNUM_W   = 8;
    localparam int SEL_W    = 4;
    localparam int ACTIVE_W = 4;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_DURATION = 3'h0;
    localparam logic [PADDR_W-1:0] REG_ACTIVE   = 3'h4;
    localparam logic [TIME_W-1:0]  DURATION_RST = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_REWIND = 2'd1,
        OP_NEXT   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [TNUM_W-1:0]   timeline_number;
        logic [TIME_W-1:0]   entry_time;
        logic [PAY_W-1:0]    entry_payload;
        logic [TIME_W-1:0]   current_time;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [SEL_W-1:0]    selected_timeline;
        logic [TIME_W-1:0]   selected_time;
        logic [PAY_W-1:0]    selected_payload;
        logic                load_overflow;
    } t_out_item;

endpackage

FILE: src/tem_ifs.sv
// request channel
interface tem_in_if;
    logic              valid;
    logic              ready;
    tem_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface tem_out_if;
    logic               valid;
    logic               ready;
    tem_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/timeline_event_merger_unit.sv
// Timeline event merger: holds NUM_TIMELINES timelines of up to ENTRIES_PER_TIMELINE
// timed entries each, all kept in one entry memory (time and payload per slot), with
// an entry count and a read cursor per timeline in flip-flops. A request beat carries
// an opcode: load appends an entry (a full timeline drops it and flags load_overflow),
// rewind moves all cursors to the first entry, clear empties all timelines, and next
// returns the earliest head entry among the active timelines (ties to the lowest
// number) and advances that cursor. A next request scans n timelines, n being the
// active timeline count clamped to NUM_TIMELINES (0 once current_time has reached
// the duration): the scan reads one head entry per cycle through the single memory
// read port, with one compare stage behind it. Every request gives exactly one result
// beat, held in an output register. Registers: duration at byte address 0x0 (reset
// all ones), active_timelines at 0x4 (reset 0); write them only while no request is
// in flight.
module timeline_event_merger_unit #(
    parameter int NUM_TIMELINES        = tem_pkg::NUM_TIMELINES_DEF,
    parameter int ENTRIES_PER_TIMELINE = tem_pkg::ENTRIES_PER_TIMELINE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tem_in_if.sink                        i_in,
    tem_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tem_pkg::PADDR_W-1:0]   paddr,
    input  logic [tem_pkg::PDATA_W-1:0]   pwdata,
    output logic [tem_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int TL_W  = (NUM_TIMELINES > 1) ? $clog2(NUM_TIMELINES) : 1;
    localparam int NT_W  = $clog2(NUM_TIMELINES + 1);
    localparam int CNT_W = $clog2(ENTRIES_PER_TIMELINE + 1);
    localparam int DEPTH = NUM_TIMELINES * ENTRIES_PER_TIMELINE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_W = tem_pkg::TIME_W + tem_pkg::PAY_W;
    localparam int TNUM_W_LOCAL = tem_pkg::TNUM_W;

    // configuration registers
    logic [tem_pkg::TIME_W-1:0]   r_duration;
    logic [tem_pkg::ACTIVE_W-1:0] r_active;
    logic                         cfg_wr;

    // per timeline state
    logic [CNT_W-1:0] r_count  [NUM_TIMELINES];
    logic [CNT_W-1:0] r_cursor [NUM_TIMELINES];

    // control and scan state
    tem_pkg::t_state              r_state;
    tem_pkg::t_state              n_state;
    logic [NT_W-1:0]              r_idx;
    logic [NT_W-1:0]              r_n;
    logic [NT_W-1:0]              eff_n;
    logic                         r_rd_vld;
    logic [TL_W-1:0]              r_rd_idx;
    logic                         r_have;
    logic [TL_W-1:0]              r_best_idx;
    logic [tem_pkg::TIME_W-1:0]   r_best_time;
    logic [tem_pkg::PAY_W-1:0]    r_best_pay;

    // output register
    logic                         r_out_valid;
    tem_pkg::t_out_item           r_out;
    tem_pkg::t_out_item           n_out;

    // memory ports
    logic [MEM_W-1:0]             r_mem [DEPTH];
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [MEM_W-1:0]             mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [MEM_W-1:0]             r_rd_data;

    // decode helpers
    logic                         acc;
    logic                         out_free;
    logic                         scan_issue;
    logic                         done_fire;
    logic [TNUM_W_LOCAL-1:0]      tnum_m1;
    logic [TL_W-1:0]              load_tl;
    logic                         load_full;
    logic [TL_W-1:0]              scan_tl;
    logic                         scan_ok;
    logic [tem_pkg::TIME_W-1:0]   rd_time;
    logic [tem_pkg::PAY_W-1:0]    rd_pay;

    // apb register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr)
            tem_pkg::REG_DURATION: prdata = r_duration;
            tem_pkg::REG_ACTIVE:   prdata = tem_pkg::PDATA_W'(r_active);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= tem_pkg::DURATION_RST;
            r_active   <= '0;
        end else if (cfg_wr) begin
            case (paddr)
                tem_pkg::REG_DURATION: r_duration <= pwdata;
                tem_pkg::REG_ACTIVE:   r_active   <= pwdata[tem_pkg::ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // load target, clamped into the timeline range
    always_comb begin
        tnum_m1 = (i_in.data.timeline_number == '0) ? '0
                : i_in.data.timeline_number - 1'b1;
        if (tnum_m1 > TNUM_W_LOCAL'(NUM_TIMELINES - 1)) begin
            tnum_m1 = TNUM_W_LOCAL'(NUM_TIMELINES - 1);
        end
        load_tl   = TL_W'(tnum_m1);
        load_full = (r_count[load_tl] >= CNT_W'(ENTRIES_PER_TIMELINE));
    end

    // active count clamped to the timeline count
    assign eff_n = (32'(r_active) > NUM_TIMELINES) ? NT_W'(NUM_TIMELINES)
                                                   : NT_W'(r_active);

    // scan head lookup
    assign scan_tl = r_idx[TL_W-1:0];
    assign scan_ok = (r_cursor[scan_tl] < r_count[scan_tl]);
    assign rd_time = r_rd_data[MEM_W-1 -: tem_pkg::TIME_W];
    assign rd_pay  = r_rd_data[tem_pkg::PAY_W-1:0];

    assign out_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tem_pkg::S_IDLE: begin
                if (acc && i_in.data.opcode == tem_pkg::OP_NEXT) begin
                    n_state = tem_pkg::S_SCAN;
                end
            end
            tem_pkg::S_SCAN: begin
                if (r_idx == r_n) begin
                    n_state = tem_pkg::S_DONE;
                end
            end
            tem_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = tem_pkg::S_IDLE;
                end
            end
            default: n_state = tem_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready = 1'b0;
        scan_issue = 1'b0;
        done_fire  = 1'b0;
        case (r_state)
            tem_pkg::S_IDLE: i_in.ready = out_free;
            tem_pkg::S_SCAN: scan_issue = (r_idx != r_n);
            tem_pkg::S_DONE: done_fire  = out_free;
            default: ;
        endcase
    end

    assign acc = i_in.valid && i_in.ready;

    // memory port controls
    assign mem_we    = acc && (i_in.data.opcode == tem_pkg::OP_LOAD) && !load_full;
    assign mem_waddr = AW'(load_tl) * AW'(ENTRIES_PER_TIMELINE) + AW'(r_count[load_tl]);
    assign mem_wdata = {i_in.data.entry_time, i_in.data.entry_payload};
    assign mem_re    = scan_issue;
    assign mem_raddr = AW'(scan_tl) * AW'(ENTRIES_PER_TIMELINE) + AW'(r_cursor[scan_tl]);

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // state register and per timeline counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tem_pkg::S_IDLE;
            r_rd_vld <= 1'b0;
            for (int k = 0; k < NUM_TIMELINES; k++) begin
                r_count[k]  <= '0;
                r_cursor[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_issue && scan_ok;
            if (acc) begin
                case (i_in.data.opcode)
                    tem_pkg::OP_LOAD: begin
                        if (!load_full) begin
                            r_count[load_tl] <= r_count[load_tl] + 1'b1;
                        end
                    end
                    tem_pkg::OP_REWIND: begin
                        for (int k = 0; k < NUM_TIMELINES; k++) begin
                            r_cursor[k] <= '0;
                        end
                    end
                    tem_pkg::OP_CLEAR: begin
                        for (int k = 0; k < NUM_TIMELINES; k++) begin
                            r_count[k]  <= '0;
                            r_cursor[k] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (done_fire && r_have) begin
                r_cursor[r_best_idx] <= r_cursor[r_best_idx] + 1'b1;
            end
        end
    end

    // scan index and running minimum
    always_ff @(posedge i_clk) begin
        if (acc && i_in.data.opcode == tem_pkg::OP_NEXT) begin
            r_idx  <= '0;
            r_n    <= (i_in.data.current_time < r_duration) ? eff_n : '0;
            r_have <= 1'b0;
        end else begin
            if (scan_issue) begin
                r_idx    <= r_idx + 1'b1;
                r_rd_idx <= scan_tl;
            end
            if (r_rd_vld && (!r_have || rd_time < r_best_time)) begin
                r_have      <= 1'b1;
                r_best_idx  <= r_rd_idx;
                r_best_time <= rd_time;
                r_best_pay  <= rd_pay;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc && i_in.data.opcode != tem_pkg::OP_NEXT) begin
            r_out_valid <= 1'b1;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next result beat
    always_comb begin
        n_out = '0;
        if (acc && i_in.data.opcode != tem_pkg::OP_NEXT) begin
            n_out.load_overflow = (i_in.data.opcode == tem_pkg::OP_LOAD) && load_full;
        end else if (r_have) begin
            n_out.found             = 1'b1;
            n_out.selected_timeline = tem_pkg::SEL_W'(7'(r_best_idx) + 7'd1);
            n_out.selected_time     = r_best_time;
            n_out.selected_payload  = r_best_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((acc && i_in.data.opcode != tem_pkg::OP_NEXT) || done_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // checks
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tem_pkg::S_SCAN |-> r_idx <= r_n)
        else $error("scan index ran past the active count");

    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != tem_pkg::S_IDLE |-> 32'(r_n) <= NUM_TIMELINES)
        else $error("scan count above timeline count");

    a_best_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tem_pkg::S_DONE && r_have |->
            r_cursor[r_best_idx] < r_count[r_best_idx])
        else $error("selected timeline has no pending entry");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_count[$past(load_tl)] == $past(r_count[load_tl]) + 1'b1)
        else $error("load did not advance the entry count");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != tem_pkg::S_IDLE |-> !i_in.ready && !mem_we)
        else $error("request taken while a next request is in flight");

endmodule
